// ----- rtl/utf8_stream_decoder_defines.svh -----
// Assertion macros used by the checker file of the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge and held off during reset.
`define UTF8SD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("utf8 stream decoder check failed");

// Next-cycle implication, sampled on the rising edge and held off during reset.
`define UTF8SD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("utf8 stream decoder check failed");

`endif

// ----- rtl/utf8sd_pkg.sv -----
// Package with the widths and constants of the UTF-8 stream decoder.
package utf8sd_pkg;

    localparam int unsigned CP_W    = 21;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned HELD_W  = 2;
    localparam int unsigned M_DATA_W = 24;

    localparam logic [CP_W-1:0] REPL_CHAR  = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_SCALAR = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_TWO    = 21'h000080;
    localparam logic [CP_W-1:0] MIN_THREE  = 21'h000800;
    localparam logic [CP_W-1:0] MIN_FOUR   = 21'h010000;

    // Value of the item kind flag carried on the input tuser.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

endpackage

// ----- rtl/utf8_stream_decoder.sv -----
// UTF-8 stream decoder with per-byte U+FFFD replacement, top level.
// Path: an accepted s_ beat waits in the input register, is decoded, and its results go
// to the result register, which drives m_. Throughput: one input beat per cycle while
// each byte yields at most one result and m_tready is high; a byte that yields n results
// (up to four, on errors) holds the result register until all n of them are taken.
// Reset: aresetn is synchronous and active low; it empties both registers and leaves the
// decoder idle with nothing held.
module utf8_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] kind: 0 data byte, 1 end of stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
    output logic        m_tlast    // last result caused by one input beat
);

    // Input register: holds one accepted beat until the decode step takes it.
    logic                            in_valid_reg;
    logic                            in_kind_reg;
    logic [utf8sd_pkg::BYTE_W-1:0]   in_byte_reg;

    // Decoder state: bytes held so far, continuation bytes the lead needs, gathered bits.
    logic [utf8sd_pkg::HELD_W-1:0]   held_reg,  held_next;
    logic [utf8sd_pkg::HELD_W-1:0]   exp_reg,   exp_next;
    logic [utf8sd_pkg::CP_W-1:0]     part_reg,  part_next;

    // Result register: beats still to deliver and the value of the final one.
    // Every beat before the final one is a replacement character.
    logic [utf8sd_pkg::CNT_W-1:0]    cnt_reg;
    logic [utf8sd_pkg::CP_W-1:0]     cp_reg;

    // Decode results for the beat in the input register.
    logic [utf8sd_pkg::CNT_W-1:0]    res_n;
    logic [utf8sd_pkg::CP_W-1:0]     res_cp;
    logic [utf8sd_pkg::CP_W-1:0]     shifted;
    logic [utf8sd_pkg::CP_W-1:0]     low_bound;
    logic [utf8sd_pkg::HELD_W-1:0]   held_inc;
    logic                            is_cont;
    logic                            bad_value;
    logic                            fresh_tail;
    logic [utf8sd_pkg::CP_W-1:0]     fresh_cp;

    logic res_last_taken;
    logic res_free;
    logic advance;
    logic load_res;

    // Handshakes. The result register frees up in the cycle its final beat is taken,
    // so a new beat moves in without a bubble.
    assign res_last_taken = m_tvalid && m_tready && (cnt_reg == utf8sd_pkg::CNT_W'(1));
    assign res_free       = (cnt_reg == '0) || res_last_taken;
    // A beat that yields no result only updates the state and never waits.
    assign advance  = in_valid_reg && ((res_n == '0) || res_free);
    assign load_res = advance && (res_n != '0);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = (cnt_reg != '0);
    assign m_tlast  = (cnt_reg == utf8sd_pkg::CNT_W'(1));
    assign m_tdata  = {3'b000, m_tlast ? cp_reg : utf8sd_pkg::REPL_CHAR};

    // Decode step. The count of results is some replacements followed, when the
    // step produces one, by a final value; res_cp holds that final value.
    always_comb begin
        is_cont   = (in_byte_reg[7:6] == 2'b10);
        shifted   = {part_reg[utf8sd_pkg::CP_W-7:0], in_byte_reg[5:0]};
        held_inc  = held_reg + utf8sd_pkg::HELD_W'(1);

        case (exp_reg)
            2'd1:    low_bound = utf8sd_pkg::MIN_TWO;
            2'd2:    low_bound = utf8sd_pkg::MIN_THREE;
            default: low_bound = utf8sd_pkg::MIN_FOUR;
        endcase
        bad_value = (shifted < low_bound)
                 || (shifted inside {[utf8sd_pkg::SURR_LO:utf8sd_pkg::SURR_HI]})
                 || (shifted > utf8sd_pkg::MAX_SCALAR);

        // A byte decoded as if the decoder were idle: ASCII passes through, a lead
        // is held, anything else is replaced.
        fresh_tail = 1'b1;
        fresh_cp   = utf8sd_pkg::REPL_CHAR;
        if (in_byte_reg[7] == 1'b0) begin
            fresh_cp = utf8sd_pkg::CP_W'(in_byte_reg);
        end else if (in_byte_reg[7:5] == 3'b110 || in_byte_reg[7:4] == 4'b1110
                     || in_byte_reg[7:3] == 5'b11110) begin
            fresh_tail = 1'b0;
        end

        held_next = held_reg;
        exp_next  = exp_reg;
        part_next = part_reg;
        res_n     = '0;
        res_cp    = utf8sd_pkg::REPL_CHAR;

        if (in_kind_reg == utf8sd_pkg::KIND_EOS) begin
            // End of stream flushes one replacement per held byte.
            res_n     = utf8sd_pkg::CNT_W'(held_reg);
            held_next = '0;
            exp_next  = '0;
            part_next = '0;
        end else if (held_reg != '0 && is_cont) begin
            held_next = held_inc;
            part_next = shifted;
            if (held_inc == '0 || held_inc > exp_reg) begin
                // Sequence complete: the value, or one replacement per byte.
                if (bad_value) begin
                    res_n = utf8sd_pkg::CNT_W'(exp_reg) + utf8sd_pkg::CNT_W'(1);
                end else begin
                    res_n  = utf8sd_pkg::CNT_W'(1);
                    res_cp = shifted;
                end
                held_next = '0;
                exp_next  = '0;
                part_next = '0;
            end
        end else begin
            // Idle, or a sequence cut short: replace the held bytes, then decode afresh.
            res_n     = utf8sd_pkg::CNT_W'(held_reg) + utf8sd_pkg::CNT_W'(fresh_tail);
            res_cp    = fresh_cp;
            held_next = '0;
            exp_next  = '0;
            part_next = '0;
            if (in_byte_reg[7:5] == 3'b110) begin
                held_next = utf8sd_pkg::HELD_W'(1);
                exp_next  = utf8sd_pkg::HELD_W'(1);
                part_next = utf8sd_pkg::CP_W'(in_byte_reg[4:0]);
            end else if (in_byte_reg[7:4] == 4'b1110) begin
                held_next = utf8sd_pkg::HELD_W'(1);
                exp_next  = utf8sd_pkg::HELD_W'(2);
                part_next = utf8sd_pkg::CP_W'(in_byte_reg[3:0]);
            end else if (in_byte_reg[7:3] == 5'b11110) begin
                held_next = utf8sd_pkg::HELD_W'(1);
                exp_next  = utf8sd_pkg::HELD_W'(3);
                part_next = utf8sd_pkg::CP_W'(in_byte_reg[2:0]);
            end
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    // Decoder state moves on when the beat leaves the input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
            exp_reg  <= '0;
            part_reg <= '0;
        end else if (advance) begin
            held_reg <= held_next;
            exp_reg  <= exp_next;
            part_reg <= part_next;
        end
    end

    // Result register: counts down one per delivered beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (load_res) begin
            cnt_reg <= res_n;
        end else if (m_tvalid && m_tready) begin
            cnt_reg <= cnt_reg - utf8sd_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load_res) begin
            cp_reg <= res_cp;
        end
    end

endmodule

// ----- rtl/utf8sd_checker.sv -----
// Port-level checker for the UTF-8 stream decoder, with its bind statement.
`include "utf8_stream_decoder_defines.svh"

module utf8sd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    logic [20:0] out_cp;
    logic        m_stall;
    logic        out_scalar;
    logic        out_repl;

    assign out_cp     = m_tdata[20:0];
    assign m_stall    = m_tvalid && !m_tready;
    assign out_scalar = (m_tdata[23:21] == 3'b000) && (out_cp <= utf8sd_pkg::MAX_SCALAR)
                     && (out_cp < utf8sd_pkg::SURR_LO || out_cp > utf8sd_pkg::SURR_HI);
    assign out_repl   = (out_cp == utf8sd_pkg::REPL_CHAR);

    // A stalled result beat stays put.
    `UTF8SD_ASSERT_NEXT(a_hold, aclk, aresetn, m_stall, m_tvalid && $stable({m_tdata, m_tlast}))

    // Every result is a Unicode scalar value with the padding bits clear.
    `UTF8SD_ASSERT_NOW(a_scalar, aclk, aresetn, m_tvalid, out_scalar)

    // Only the final result of a beat can be a decoded value; earlier ones are replacements.
    `UTF8SD_ASSERT_NOW(a_repl_first, aclk, aresetn, m_tvalid && !m_tlast, out_repl)

    // Nothing comes out in the cycle after reset is released.
    `UTF8SD_ASSERT_NEXT(a_quiet_after_reset, aclk, aresetn, $rose(aresetn), !m_tvalid)

endmodule

bind utf8_stream_decoder utf8sd_checker u_utf8sd_checker (.*);

// ----- sim/utf8_stream_decoder_tb.sv -----
// Self-checking testbench for the UTF-8 stream decoder, with a built-in decode predictor.
`timescale 1ns / 100ps

module utf8_stream_decoder_tb;

    localparam int TOTAL_BEATS  = 450;   // directed and random beats together
    localparam int HOLD_AT      = 120;   // input beats accepted before the long sink stall
    localparam int HOLD_CYCLES  = 300;
    localparam int CALM_FROM    = 300;   // stretch of input beats with no idling at all
    localparam int CALM_TO      = 380;
    localparam int STALL_LIMIT  = 2000;  // cycles without any handshake before giving up
    localparam int MAX_PRINTED  = 40;

    typedef struct packed {
        logic       drain_mark;  // not a beat: sender waits here until all results are in
        logic       kind;
        logic [7:0] data_byte;
    } in_beat_t;

    typedef struct packed {
        logic [utf8sd_pkg::CP_W-1:0] code_point;
        logic                        last;
    } cp_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = utf8sd_pkg::KIND_DATA;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    in_beat_t                    beat_q[$];
    cp_result_t                  cp_expect_q[$];
    logic [utf8sd_pkg::CP_W-1:0] step_cps[$];

    // Predictor state: bytes held (lead included), continuations the lead needs, and
    // the value bits gathered so far.
    logic [1:0]                  dec_held = 2'd0;
    logic [1:0]                  dec_need = 2'd0;
    logic [utf8sd_pkg::CP_W-1:0] dec_acc  = '0;

    int in_count = 0;
    int sent_count = 0;
    int out_count = 0;
    int err_count = 0;
    int repl_count = 0;
    int eos_count = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    utf8_stream_decoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Decode predictor
    // ------------------------------------------------------------------
    task automatic add_repl(input int count);
        int i;
        for (i = 0; i < count; i++) step_cps.push_back(utf8sd_pkg::REPL_CHAR);
    endtask

    task automatic clear_held();
        dec_held = 2'd0;
        dec_need = 2'd0;
        dec_acc  = '0;
    endtask

    // Decodes a byte as if nothing were held: ASCII passes through, a lead byte starts
    // a sequence, anything else is rejected on its own.
    task automatic decode_fresh_byte(input logic [7:0] b);
        if (b[7] == 1'b0) begin
            step_cps.push_back({13'd0, b});
        end else if (b[7:5] == 3'b110) begin
            dec_held = 2'd1; dec_need = 2'd1; dec_acc = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            dec_held = 2'd1; dec_need = 2'd2; dec_acc = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            dec_held = 2'd1; dec_need = 2'd3; dec_acc = {18'd0, b[2:0]};
        end else begin
            step_cps.push_back(utf8sd_pkg::REPL_CHAR);
        end
    endtask

    task automatic predict_code_points(input logic kind, input logic [7:0] b);
        logic [utf8sd_pkg::CP_W-1:0] floor_cp;
        int i;
        step_cps.delete();
        if (kind == utf8sd_pkg::KIND_EOS) begin
            eos_count++;
            add_repl(int'(dec_held));
            clear_held();
        end else if (dec_held != 2'd0) begin
            if (b[7:6] == 2'b10) begin
                dec_acc  = {dec_acc[utf8sd_pkg::CP_W-7:0], b[5:0]};
                dec_held = dec_held + 2'd1;   // wraps to zero after the third continuation
                if (dec_held == 2'd0 || dec_held > dec_need) begin
                    floor_cp = (dec_need == 2'd1) ? utf8sd_pkg::MIN_TWO :
                               (dec_need == 2'd2) ? utf8sd_pkg::MIN_THREE :
                                                    utf8sd_pkg::MIN_FOUR;
                    // Overlong, surrogate and out-of-range values reject every byte.
                    if (dec_acc < floor_cp ||
                        (dec_acc >= utf8sd_pkg::SURR_LO && dec_acc <= utf8sd_pkg::SURR_HI) ||
                        dec_acc > utf8sd_pkg::MAX_SCALAR)
                        add_repl(int'(dec_need) + 1);
                    else
                        step_cps.push_back(dec_acc);
                    clear_held();
                end
            end else begin
                // Interrupted sequence: flush the held bytes, then decode this one afresh.
                add_repl(int'(dec_held));
                clear_held();
                decode_fresh_byte(b);
            end
        end else begin
            decode_fresh_byte(b);
        end
        for (i = 0; i < step_cps.size(); i++)
            cp_expect_q.push_back('{code_point: step_cps[i], last: (i == step_cps.size() - 1)});
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] b);
        beat_q.push_back('{drain_mark: 1'b0, kind: utf8sd_pkg::KIND_DATA, data_byte: b});
    endtask

    task automatic queue_eos(input logic [7:0] junk);
        beat_q.push_back('{drain_mark: 1'b0, kind: utf8sd_pkg::KIND_EOS, data_byte: junk});
    endtask

    task automatic queue_drain();
        beat_q.push_back('{drain_mark: 1'b1, kind: utf8sd_pkg::KIND_DATA, data_byte: 8'h00});
    endtask

    // Encodes cp in nbytes bytes and queues the first keep of them.
    task automatic queue_utf8(input logic [utf8sd_pkg::CP_W-1:0] cp, input int nbytes,
                              input int keep);
        logic [7:0] seq [4];
        int k;
        case (nbytes)
            1: begin
                seq[0] = {1'b0, cp[6:0]};
            end
            2: begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3: begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default: begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (k = 0; k < keep; k++) queue_byte(seq[k]);
    endtask

    function automatic logic [utf8sd_pkg::CP_W-1:0] pick_code_point(input int nbytes);
        case (nbytes)
            1:       return utf8sd_pkg::CP_W'($urandom_range(21'h00007F, 21'h000000));
            2:       return utf8sd_pkg::CP_W'($urandom_range(21'h0007FF, 21'h000080));
            3:       return utf8sd_pkg::CP_W'($urandom_range(21'h00FFFF, 21'h000800));
            default: return utf8sd_pkg::CP_W'($urandom_range(21'h10FFFF, 21'h010000));
        endcase
    endfunction

    // Reports one mismatch; after a burst of them only the count goes on.
    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < MAX_PRINTED)
            $display("%0t ns: MISMATCH %s: got %h, expected %h (result %0d)",
                     $realtime, what, got, want, out_count);
        else if (err_count == MAX_PRINTED)
            $display("further mismatches are counted but not printed");
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Input driver: one beat at a time from beat_q, updated on the falling edge.
    // A beat is in flight while sent_count is ahead of in_count.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : drive_input
        in_beat_t nxt;
        bit       calm;
        calm = (in_count >= CALM_FROM && in_count < CALM_TO);
        if (aresetn && in_count == sent_count) begin
            if (beat_q.size() != 0 && beat_q[0].drain_mark && cp_expect_q.size() == 0)
                void'(beat_q.pop_front());
            if (beat_q.size() == 0 || beat_q[0].drain_mark ||
                (!calm && $urandom_range(99) < 30)) begin
                s_tvalid <= 1'b0;
            end else begin
                nxt = beat_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.data_byte;
                s_tuser  <= nxt.kind;
                sent_count++;
            end
        end
    end

    // Sink ready: random stalls, one long hold-off that backs the block up into its
    // input, and a calm stretch with ready held high.
    always @(negedge aclk) begin : drive_ready
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (!hold_done && in_count >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= (in_count >= CALM_FROM && in_count < CALM_TO) ||
                        ($urandom_range(99) >= 30);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on each accepted input beat and checks each result beat.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        cp_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_code_points(s_tuser, s_tdata);
                in_count++;
            end
            if (m_tvalid && m_tready) begin
                if (cp_expect_q.size() == 0) begin
                    report_mismatch("unexpected result, code point", int'(m_tdata), 0);
                end else begin
                    want = cp_expect_q.pop_front();
                    if (m_tdata[utf8sd_pkg::CP_W-1:0] != want.code_point)
                        report_mismatch("code point", int'(m_tdata[utf8sd_pkg::CP_W-1:0]),
                                        int'(want.code_point));
                    if (m_tdata[23:utf8sd_pkg::CP_W] != '0)
                        report_mismatch("tdata padding", int'(m_tdata[23:utf8sd_pkg::CP_W]), 0);
                    if (m_tlast != want.last)
                        report_mismatch("last flag", int'(m_tlast), int'(want.last));
                    if (want.code_point == utf8sd_pkg::REPL_CHAR) repl_count++;
                end
                out_count++;
            end
        end
    end

    // Watchdog: ends the run if neither side has moved a beat for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no handshake for %0d cycles, %0d results still expected",
                 STALL_LIMIT, cp_expect_q.size());
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        int sel;
        int nbytes;
        int keep;
        int k;
        logic [7:0] lead;

        // Directed: ASCII extremes, stray continuation, invalid lead.
        queue_byte(8'h00);
        queue_byte(8'h7F);
        queue_byte(8'h80);
        queue_byte(8'hFF);
        // Smallest two-byte value, then an overlong two-byte form.
        queue_utf8(21'h000080, 2, 2);
        queue_byte(8'hC0); queue_byte(8'h80);
        // Surrogate, largest scalar, and an F5 lead that fails only at completion.
        queue_byte(8'hED); queue_byte(8'hA0); queue_byte(8'h80);
        queue_utf8(utf8sd_pkg::MAX_SCALAR, 4, 4);
        queue_byte(8'hF5); queue_byte(8'h80); queue_byte(8'h80); queue_byte(8'h80);
        // Sequence cut short by ASCII; a three-byte hold cut by an invalid lead gives
        // the most results one beat can cause.
        queue_byte(8'hE2); queue_byte(8'h82); queue_byte(8'h41);
        queue_byte(8'hF0); queue_byte(8'h90); queue_byte(8'h80); queue_byte(8'hF8);
        // End of stream with a lead held, then with nothing held.
        queue_byte(8'hC3); queue_eos(8'hFF);
        queue_eos(8'h00);
        queue_drain();

        // Random: mostly well-formed sequences, the rest broken sequences and noise.
        while (beat_q.size() < TOTAL_BEATS) begin
            if (beat_q.size() == TOTAL_BEATS / 2) queue_drain();
            sel = $urandom_range(99);
            if (sel < 60) begin
                nbytes = $urandom_range(4, 1);
                queue_utf8(pick_code_point(nbytes), nbytes, nbytes);
            end else if (sel < 72) begin
                nbytes = $urandom_range(4, 2);
                keep = $urandom_range(nbytes - 1, 1);
                queue_utf8(pick_code_point(nbytes), nbytes, keep);
                if ($urandom_range(3) == 0)
                    queue_eos(8'($urandom_range(255)));
                else
                    queue_byte(8'($urandom_range(255)));
            end else if (sel < 82) begin
                // Any lead with random continuations: reaches overlong, surrogate and
                // out-of-range completions.
                lead = 8'($urandom_range(8'hF7, 8'hC0));
                nbytes = (lead[7:5] == 3'b110) ? 2 : (lead[7:4] == 4'b1110) ? 3 : 4;
                queue_byte(lead);
                for (k = 1; k < nbytes; k++) queue_byte({2'b10, 6'($urandom_range(63))});
            end else if (sel < 92) begin
                queue_byte(8'($urandom_range(255)));
            end else begin
                queue_eos(8'($urandom_range(255)));
            end
        end

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        while (beat_q.size() != 0 || in_count != sent_count) @(posedge aclk);
        while (cp_expect_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("covered %0d input beats (%0d end-of-stream) and %0d code points out",
                 in_count, eos_count, out_count);
        $display("replacement characters among them: %0d; long sink stall and drain pause done",
                 repl_count);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/utf8sd_pkg.sv
rtl/utf8_stream_decoder.sv
rtl/utf8sd_checker.sv
sim/utf8_stream_decoder_tb.sv
